// ===== rtl/core/tevq_pkg.sv =====
package tevq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_OUT     = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int EMIT_W      = $clog2(MAX_OUT + 1);

    localparam logic [2:0] MODE_SCHEDULE   = 3'd0;
    localparam logic [2:0] MODE_REPLACE    = 3'd1;
    localparam logic [2:0] MODE_CANCEL_OBJ = 3'd2;
    localparam logic [2:0] MODE_CANCEL_REQ = 3'd3;
    localparam logic [2:0] MODE_TICK       = 3'd4;

    localparam logic [2:0] KIND_SCHEDULED  = 3'd0;
    localparam logic [2:0] KIND_DISPATCHED = 3'd1;
    localparam logic [2:0] KIND_CANCELED   = 3'd2;
    localparam logic [2:0] KIND_FULL       = 3'd3;
    localparam logic [2:0] KIND_REJECTED   = 3'd4;

    localparam logic [30:0] ID_MAX = 31'h7FFF_FFFF;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_POP    = 2'd3
    } cell_op_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] due;
        logic [30:0] id;
        logic [31:0] obj;
        logic        pkind;
        logic [31:0] pval;
    } entry_t;

    typedef struct packed {
        cell_op_t    op;
        logic        by_object;
        logic        key_ok;
        logic [31:0] key;
        entry_t      new_entry;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/tevq_cell.sv =====
module tevq_cell import tevq_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl,
    input  entry_t     left_entry,
    input  logic       left_lt,
    input  entry_t     right_entry,
    input  logic       match_in,
    output entry_t     entry,
    output logic       lt,
    output logic       match_out
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   match;

    // Earlier due time than the entry being inserted; valid cells form a sorted prefix.
    assign lt    = entry_reg.valid && (entry_reg.due < ctrl.new_entry.due);
    assign match = entry_reg.valid && ctrl.key_ok &&
                   (ctrl.by_object ? (entry_reg.obj == ctrl.key)
                                   : (entry_reg.id == ctrl.key[30:0]));
    assign match_out = match_in | match;
    assign entry     = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        unique case (ctrl.op)
            OP_HOLD: begin
                entry_next = entry_reg;
            end
            OP_INSERT: begin
                if (!lt) begin
                    entry_next = left_lt ? ctrl.new_entry : left_entry;
                end
            end
            OP_REMOVE: begin
                if (match_out) begin
                    entry_next = right_entry;
                end
            end
            OP_POP: begin
                entry_next = right_entry;
            end
            default: entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= '0;
        end else begin
            entry_reg <= entry_next;
        end
    end

endmodule

// ===== rtl/core/timed_event_queue_top.sv =====
// Time-ordered event queue built as a row of QUEUE_DEPTH cells, head in cell 0.
// Input channel s_*: one command per transfer (schedule, replace, cancel by object,
// cancel by request, tick). s_ready is high only while no command is in progress.
// Result channel m_*: one result per schedule, replace or cancel, and one result
// per dispatched entry for a tick; m_last marks the final result of a command.
// A tick with nothing due and modes 5 to 7 produce no result.
// A schedule gives its result from the schedule state after the transfer. A cancel
// or replace removes one matching entry at a time until no further match is found;
// a replace then schedules its new entry. A tick dispatches one due entry per cycle
// from the head while the receiver accepts results, at most 16 per tick.
// The result is held in an output register; while the receiver stalls, the block
// waits with the next result and does not pop or insert, but removals go on.
// Reset (aresetn low, synchronous) empties the queue, clears the simulated time
// and the request id counter, and drops any pending result.
module timed_event_queue_top import tevq_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [31:0] s_object_id,
    input  logic signed [31:0] s_delay,
    input  logic        s_payload_kind,
    input  logic [31:0] s_payload,
    input  logic [30:0] s_request_id,
    input  logic [31:0] s_now_time,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [30:0] m_assigned_id,
    output logic [31:0] m_target_object,
    output logic        m_call_kind,
    output logic [31:0] m_call_value,
    output logic [4:0]  m_removed_count,
    output logic        m_last
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_REMOVE = 4'b0010,
        ST_SCHED  = 4'b0100,
        ST_TICK   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Command captured at the input transfer.
    logic [2:0]  mode_reg;
    logic [31:0] obj_reg;
    logic        pkind_reg;
    logic [31:0] pval_reg;
    logic [30:0] req_reg;
    logic [31:0] due_reg;
    logic [31:0] sim_time_reg, sim_time_next;
    logic [30:0] id_reg, id_next;
    logic [CNT_W-1:0]  removed_reg, removed_next;
    logic [EMIT_W-1:0] emit_reg, emit_next;

    logic        m_valid_reg;
    logic [2:0]  m_kind_reg;
    logic [30:0] m_id_reg;
    logic [31:0] m_obj_reg;
    logic        m_ck_reg;
    logic [31:0] m_cv_reg;
    logic [4:0]  m_rc_reg;
    logic        m_last_reg;

    cell_ctrl_t ctrl;
    entry_t     cell_entry [QUEUE_DEPTH];
    logic       cell_lt    [QUEUE_DEPTH];
    logic       cell_match [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] valid_vec;

    logic        s_fire;
    logic        out_free;
    logic        emit;
    logic [2:0]  e_kind;
    logic [30:0] e_id;
    logic [31:0] e_obj;
    logic        e_ck;
    logic [31:0] e_cv;
    logic        e_last;
    logic [31:0] dly_eff;
    logic        head_due;
    logic        second_due;
    logic        any_match;
    logic        by_obj;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // A delay below one tick counts as one tick.
    assign dly_eff = (s_delay[31] || (s_delay == 32'sd0)) ? 32'd1 : s_delay;

    assign by_obj     = (mode_reg == MODE_CANCEL_OBJ);
    assign head_due   = cell_entry[0].valid && (cell_entry[0].due <= sim_time_reg);
    assign second_due = cell_entry[1].valid && (cell_entry[1].due <= sim_time_reg);
    assign any_match  = cell_match[QUEUE_DEPTH-1];

    generate
        for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
            entry_t left_e;
            entry_t right_e;
            logic   left_lt;
            logic   m_in;
            assign valid_vec[i] = cell_entry[i].valid;
            if (i == 0) begin : g_head
                assign left_e  = ctrl.new_entry;
                assign left_lt = 1'b1;
                assign m_in    = 1'b0;
            end else begin : g_body
                assign left_e  = cell_entry[i-1];
                assign left_lt = cell_lt[i-1];
                assign m_in    = cell_match[i-1];
            end
            if (i == QUEUE_DEPTH - 1) begin : g_tail
                assign right_e = '0;
            end else begin : g_inner
                assign right_e = cell_entry[i+1];
            end
            tevq_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (ctrl),
                .left_entry  (left_e),
                .left_lt     (left_lt),
                .right_entry (right_e),
                .match_in    (m_in),
                .entry       (cell_entry[i]),
                .lt          (cell_lt[i]),
                .match_out   (cell_match[i])
            );
        end
    endgenerate

    always_comb begin
        state_next    = state_reg;
        sim_time_next = sim_time_reg;
        id_next       = id_reg;
        removed_next  = removed_reg;
        emit_next     = emit_reg;
        emit          = 1'b0;
        e_kind        = KIND_SCHEDULED;
        e_id          = '0;
        e_obj         = '0;
        e_ck          = 1'b0;
        e_cv          = '0;
        e_last        = 1'b1;

        ctrl.op              = OP_HOLD;
        ctrl.by_object       = by_obj;
        ctrl.key_ok          = by_obj ? (obj_reg != 32'd0) : (req_reg != 31'd0);
        ctrl.key             = by_obj ? obj_reg : {1'b0, req_reg};
        ctrl.new_entry.valid = 1'b1;
        ctrl.new_entry.due   = due_reg;
        ctrl.new_entry.id    = (id_reg == ID_MAX) ? 31'd1 : id_reg + 31'd1;
        ctrl.new_entry.obj   = obj_reg;
        ctrl.new_entry.pkind = pkind_reg;
        ctrl.new_entry.pval  = pval_reg;

        unique case (state_reg)
            ST_IDLE: begin
                removed_next = '0;
                emit_next    = '0;
                if (s_fire) begin
                    unique case (s_mode)
                        MODE_SCHEDULE:   state_next = ST_SCHED;
                        MODE_REPLACE:    state_next = ST_REMOVE;
                        MODE_CANCEL_OBJ: state_next = ST_REMOVE;
                        MODE_CANCEL_REQ: state_next = ST_REMOVE;
                        MODE_TICK: begin
                            state_next    = ST_TICK;
                            sim_time_next = s_now_time;
                        end
                        default:         state_next = ST_IDLE;
                    endcase
                end
            end
            ST_REMOVE: begin
                if (any_match) begin
                    ctrl.op      = OP_REMOVE;
                    removed_next = removed_reg + CNT_W'(1);
                end else if (mode_reg == MODE_REPLACE) begin
                    state_next = ST_SCHED;
                end else if (out_free) begin
                    emit       = 1'b1;
                    e_kind     = KIND_CANCELED;
                    state_next = ST_IDLE;
                end
            end
            ST_SCHED: begin
                if (out_free) begin
                    emit       = 1'b1;
                    id_next    = ctrl.new_entry.id;
                    state_next = ST_IDLE;
                    if (!pkind_reg && (pval_reg == 32'd0)) begin
                        e_kind = KIND_REJECTED;
                    end else if (cell_entry[QUEUE_DEPTH-1].valid) begin
                        e_kind = KIND_FULL;
                    end else begin
                        e_kind  = KIND_SCHEDULED;
                        e_id    = ctrl.new_entry.id;
                        ctrl.op = OP_INSERT;
                    end
                end
            end
            ST_TICK: begin
                if (!head_due || (emit_reg == EMIT_W'(MAX_OUT))) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    emit      = 1'b1;
                    ctrl.op   = OP_POP;
                    emit_next = emit_reg + EMIT_W'(1);
                    e_kind    = KIND_DISPATCHED;
                    e_id      = cell_entry[0].id;
                    e_obj     = cell_entry[0].obj;
                    e_ck      = cell_entry[0].pkind;
                    e_cv      = cell_entry[0].pval;
                    e_last    = !second_due || (emit_reg == EMIT_W'(MAX_OUT - 1));
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            sim_time_reg <= '0;
            id_reg       <= '0;
            removed_reg  <= '0;
            emit_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sim_time_reg <= sim_time_next;
            id_reg       <= id_next;
            removed_reg  <= removed_next;
            emit_reg     <= emit_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            mode_reg  <= s_mode;
            obj_reg   <= s_object_id;
            pkind_reg <= s_payload_kind;
            pval_reg  <= s_payload;
            req_reg   <= s_request_id;
            due_reg   <= sim_time_reg + dly_eff;
        end
        if (emit) begin
            m_kind_reg <= e_kind;
            m_id_reg   <= e_id;
            m_obj_reg  <= e_obj;
            m_ck_reg   <= e_ck;
            m_cv_reg   <= e_cv;
            m_rc_reg   <= (e_kind == KIND_DISPATCHED) ? 5'd0 : 5'(removed_reg);
            m_last_reg <= e_last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_kind          = m_kind_reg;
    assign m_assigned_id   = m_id_reg;
    assign m_target_object = m_obj_reg;
    assign m_call_kind     = m_ck_reg;
    assign m_call_value    = m_cv_reg;
    assign m_removed_count = m_rc_reg;
    assign m_last          = m_last_reg;

    // Valid entries always occupy a contiguous run from the head.
    a_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        ((valid_vec & (valid_vec + QUEUE_DEPTH'(1))) == '0))
        else $error("queue entries are not contiguous from the head");

    // A result is never overwritten while the receiver stalls.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !emit)
        else $error("pending result overwritten");

    // During a tick, entries are popped from the head only when a dispatch result is produced.
    a_pop_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == OP_POP) |-> (emit && head_due))
        else $error("entry popped without a dispatch result");

    // A valid command is never dropped after its transfer: the block leaves idle for it.
    a_accept_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (state_reg != ST_IDLE) || (mode_reg != MODE_SCHEDULE &&
                   mode_reg != MODE_REPLACE && mode_reg != MODE_CANCEL_OBJ &&
                   mode_reg != MODE_CANCEL_REQ && mode_reg != MODE_TICK))
        else $error("command dropped after transfer");

endmodule
